>>> rtl/gpio_port_with_edge_interrupts_macros.svh
// Assertion macros shared by the GPIO port RTL.
`ifndef GPIO_PORT_WITH_EDGE_INTERRUPTS_MACROS_SVH
`define GPIO_PORT_WITH_EDGE_INTERRUPTS_MACROS_SVH

// Check a consequence in the same cycle; expects clk and rst in scope.
`define GPIOEI_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gpio port check failed");

// Check a consequence in the following cycle; expects clk and rst in scope.
`define GPIOEI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gpio port check failed");

`endif

>>> rtl/gpioei_pkg.sv
// Types, codes and pin masks for the GPIO port with edge interrupts.
package gpioei_pkg;

  localparam int NUM_PINS = 16;

  // Implemented-pin masks for 1-, 2- and 4-bit per-pin fields
  localparam logic [15:0] PIN_MASK   = 16'((64'h1 << NUM_PINS) - 64'h1);
  localparam logic [31:0] FIELD2_MASK = 32'((64'h1 << (2 * NUM_PINS)) - 64'h1);
  localparam int AF_LO_PINS = (NUM_PINS < 8) ? NUM_PINS : 8;
  localparam int AF_HI_PINS = (NUM_PINS > 8) ? (NUM_PINS - 8) : 0;
  localparam logic [31:0] AF_LO_MASK = 32'((64'h1 << (4 * AF_LO_PINS)) - 64'h1);
  localparam logic [31:0] AF_HI_MASK = 32'((64'h1 << (4 * AF_HI_PINS)) - 64'h1);

  localparam logic [1:0] MODE_OUTPUT    = 2'b01;
  localparam logic [1:0] MODE_ALTERNATE = 2'b10;

  typedef enum logic [1:0] {
    FUNC_READ   = 2'd0,
    FUNC_WRITE  = 2'd1,
    FUNC_SAMPLE = 2'd2
  } func_t;

  typedef enum logic [3:0] {
    REG_MODE    = 4'd0,
    REG_OTYPE   = 4'd1,
    REG_SPEED   = 4'd2,
    REG_PULL    = 4'd3,
    REG_IDR     = 4'd4,
    REG_ODR     = 4'd5,
    REG_AFLOW   = 4'd6,
    REG_AFHIGH  = 4'd7,
    REG_RISE    = 4'd8,
    REG_FALL    = 4'd9,
    REG_MASK    = 4'd10,
    REG_PENDING = 4'd11
  } reg_sel_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  reg_sel;
    logic [31:0] write_data;
    logic [15:0] pin_levels;
  } item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [15:0] pin_drive;
    logic [15:0] pin_out_enable;
    logic        irq;
  } result_t;

endpackage

>>> rtl/gpioei_regs.sv
// Register bank, edge detector and result logic of the GPIO port.
`include "gpio_port_with_edge_interrupts_macros.svh"

module gpioei_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  gpioei_pkg::item_t   item,
  output gpioei_pkg::result_t result
);

  logic [31:0] mode_bits, mode_bits_next;
  logic [15:0] out_type_bits, out_type_bits_next;
  logic [31:0] speed_bits, speed_bits_next;
  logic [31:0] pull_bits, pull_bits_next;
  logic [15:0] input_data, input_data_next;
  logic [15:0] output_data, output_data_next;
  logic [31:0] altfn_low, altfn_low_next;
  logic [31:0] altfn_high, altfn_high_next;
  logic [15:0] rise_select, rise_select_next;
  logic [15:0] fall_select, fall_select_next;
  logic [15:0] irq_mask, irq_mask_next;
  logic [15:0] pending_flags, pending_flags_next;

  logic [15:0] levels_now;
  logic [15:0] rising;
  logic [15:0] falling;
  logic [15:0] wdata16;
  logic [31:0] rdata;
  logic [15:0] out_en;

  assign levels_now = item.pin_levels & gpioei_pkg::PIN_MASK;
  assign rising     = levels_now & ~input_data;
  assign falling    = ~levels_now & input_data;
  assign wdata16    = item.write_data[15:0] & gpioei_pkg::PIN_MASK;

  // Select the register for a read
  always_comb begin
    unique case (item.reg_sel)
      gpioei_pkg::REG_MODE:    rdata = mode_bits;
      gpioei_pkg::REG_OTYPE:   rdata = {16'h0, out_type_bits};
      gpioei_pkg::REG_SPEED:   rdata = speed_bits;
      gpioei_pkg::REG_PULL:    rdata = pull_bits;
      gpioei_pkg::REG_IDR:     rdata = {16'h0, input_data};
      gpioei_pkg::REG_ODR:     rdata = {16'h0, output_data};
      gpioei_pkg::REG_AFLOW:   rdata = altfn_low;
      gpioei_pkg::REG_AFHIGH:  rdata = altfn_high;
      gpioei_pkg::REG_RISE:    rdata = {16'h0, rise_select};
      gpioei_pkg::REG_FALL:    rdata = {16'h0, fall_select};
      gpioei_pkg::REG_MASK:    rdata = {16'h0, irq_mask};
      gpioei_pkg::REG_PENDING: rdata = {16'h0, pending_flags};
      default:                 rdata = 32'h0;
    endcase
  end

  // Work out the state after the item
  always_comb begin
    mode_bits_next     = mode_bits;
    out_type_bits_next = out_type_bits;
    speed_bits_next    = speed_bits;
    pull_bits_next     = pull_bits;
    input_data_next    = input_data;
    output_data_next   = output_data;
    altfn_low_next     = altfn_low;
    altfn_high_next    = altfn_high;
    rise_select_next   = rise_select;
    fall_select_next   = fall_select;
    irq_mask_next      = irq_mask;
    pending_flags_next = pending_flags;
    unique case (item.func)
      gpioei_pkg::FUNC_WRITE: begin
        unique case (item.reg_sel)
          gpioei_pkg::REG_MODE:   mode_bits_next  = item.write_data & gpioei_pkg::FIELD2_MASK;
          gpioei_pkg::REG_OTYPE:  out_type_bits_next = wdata16;
          gpioei_pkg::REG_SPEED:  speed_bits_next = item.write_data & gpioei_pkg::FIELD2_MASK;
          gpioei_pkg::REG_PULL:   pull_bits_next  = item.write_data & gpioei_pkg::FIELD2_MASK;
          gpioei_pkg::REG_ODR:    output_data_next = wdata16;
          gpioei_pkg::REG_AFLOW:  altfn_low_next  = item.write_data & gpioei_pkg::AF_LO_MASK;
          gpioei_pkg::REG_AFHIGH: altfn_high_next = item.write_data & gpioei_pkg::AF_HI_MASK;
          gpioei_pkg::REG_RISE:   rise_select_next = wdata16;
          gpioei_pkg::REG_FALL:   fall_select_next = wdata16;
          gpioei_pkg::REG_MASK:   irq_mask_next    = wdata16;
          // Clear pending bits written as one
          gpioei_pkg::REG_PENDING: pending_flags_next = pending_flags & ~wdata16;
          // Input data is read-only; unknown selects drop the write
          default: ;
        endcase
      end
      gpioei_pkg::FUNC_SAMPLE: begin
        pending_flags_next = pending_flags
                           | (((rising & rise_select) | (falling & fall_select))
                              & gpioei_pkg::PIN_MASK);
        input_data_next    = levels_now;
      end
      default: ;
    endcase
  end

  // Output enable for pins in general output or alternate mode
  always_comb begin
    out_en = 16'h0;
    for (int p = 0; p < 16; p++) begin
      if (mode_bits_next[2*p +: 2] == gpioei_pkg::MODE_OUTPUT ||
          mode_bits_next[2*p +: 2] == gpioei_pkg::MODE_ALTERNATE) begin
        out_en[p] = 1'b1;
      end
    end
  end

  assign result.read_data      = (item.func == gpioei_pkg::FUNC_READ) ? rdata : 32'h0;
  assign result.pin_drive      = output_data_next;
  assign result.pin_out_enable = out_en & gpioei_pkg::PIN_MASK;
  assign result.irq            = |(pending_flags_next & irq_mask_next);

  // Update the register bank on an accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_bits     <= '0;
      out_type_bits <= '0;
      speed_bits    <= '0;
      pull_bits     <= '0;
      input_data    <= '0;
      output_data   <= '0;
      altfn_low     <= '0;
      altfn_high    <= '0;
      rise_select   <= '0;
      fall_select   <= '0;
      irq_mask      <= '0;
      pending_flags <= '0;
    end else if (accept) begin
      mode_bits     <= mode_bits_next;
      out_type_bits <= out_type_bits_next;
      speed_bits    <= speed_bits_next;
      pull_bits     <= pull_bits_next;
      input_data    <= input_data_next;
      output_data   <= output_data_next;
      altfn_low     <= altfn_low_next;
      altfn_high    <= altfn_high_next;
      rise_select   <= rise_select_next;
      fall_select   <= fall_select_next;
      irq_mask      <= irq_mask_next;
      pending_flags <= pending_flags_next;
    end
  end

  // A write never sets a pending flag
  `GPIOEI_ASSERT_NEXT(a_write_no_set, accept && item.func == gpioei_pkg::FUNC_WRITE, (pending_flags & ~$past(pending_flags)) == 16'h0)
  // Only a sample moves the input data
  `GPIOEI_ASSERT_NEXT(a_idr_sample_only, accept && item.func != gpioei_pkg::FUNC_SAMPLE, $stable(input_data))
  // A sample raises pending flags only on pins with an edge selected
  `GPIOEI_ASSERT_NEXT(a_pend_selected, accept && item.func == gpioei_pkg::FUNC_SAMPLE, (pending_flags & ~$past(pending_flags) & ~($past(rise_select) | $past(fall_select))) == 16'h0)

endmodule

>>> rtl/gpio_port_with_edge_interrupts.sv
// Top level of the 16-pin GPIO port with edge interrupts.
//
// Each item (register read, register write or pin sample) updates the register bank and
// the result register at the edge that accepts it, and the result shows on the output
// in the following cycle with the state left after the item. One item is accepted
// every cycle while the output side takes results; the single result register is the
// only buffer, so while a result is held a stall on the output stalls the input in the
// same cycle.
`include "gpio_port_with_edge_interrupts_macros.svh"

module gpio_port_with_edge_interrupts (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [3:0]  reg_sel,
  input  logic [31:0] write_data,
  input  logic [15:0] pin_levels,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] read_data,
  output logic [15:0] pin_drive,
  output logic [15:0] pin_out_enable,
  output logic        irq
);

  gpioei_pkg::item_t   item;
  gpioei_pkg::result_t result_next;
  gpioei_pkg::result_t result;
  logic                accept;

  assign item.func       = func;
  assign item.reg_sel    = reg_sel;
  assign item.write_data = write_data;
  assign item.pin_levels = pin_levels;

  // Hold the input while a result waits on a stalled output
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  gpioei_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .result (result_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= accept | (out_valid & out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  assign read_data      = result.read_data;
  assign pin_drive      = result.pin_drive;
  assign pin_out_enable = result.pin_out_enable;
  assign irq            = result.irq;

  // An accepted item always leaves a result behind
  `GPIOEI_ASSERT_NEXT(a_accept_result, accept, out_valid)
  // The input only stalls behind a held result
  `GPIOEI_ASSERT_SAME(a_stall_held, in_stall, out_valid && out_stall)
  // A held result keeps its value
  `GPIOEI_ASSERT_NEXT(a_result_hold, out_valid && out_stall, $stable(result))

endmodule

>>> verif/gpio_port_with_edge_interrupts_test.sv
// Self-checking testbench for the 16-pin GPIO port with edge interrupts.
`timescale 1ns / 1ps

module gpio_port_with_edge_interrupts_test;

  // Codes outside the package enums
  localparam logic [1:0] FUNC_NONE        = 2'd3;
  localparam logic [3:0] REG_UNUSED_FIRST = 4'd12;
  localparam logic [3:0] REG_UNUSED_LAST  = 4'd15;

  localparam int IDLE_LIMIT   = 2000;
  localparam int LONG_HOLD    = 300;
  localparam int FILL_ITEMS   = 30;
  localparam int PHASE_ITEMS  = 135;
  localparam int NUM_PHASES   = 5;
  localparam int TAIL_CYCLES  = 4;
  localparam int NUM_ROWS     = 27;

  typedef struct packed {
    gpioei_pkg::item_t   item;
    logic                typed;
    gpioei_pkg::result_t want;
  } row_t;

  // Directed rows; typed rows carry their own expected result
  localparam row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{'{gpioei_pkg::FUNC_READ,  gpioei_pkg::REG_MODE,    32'h0000_0000, 16'h0000}, 1'b1,
      '{32'h0000_0000, 16'h0000, 16'h0000, 1'b0}},
    '{'{gpioei_pkg::FUNC_WRITE, gpioei_pkg::REG_ODR,     32'hFFFF_FFFF, 16'h0000}, 1'b1,
      '{32'h0000_0000, 16'hFFFF, 16'h0000, 1'b0}},
    '{'{gpioei_pkg::FUNC_READ,  gpioei_pkg::REG_ODR,     32'h0000_0000, 16'hFFFF}, 1'b1,
      '{32'h0000_FFFF, 16'hFFFF, 16'h0000, 1'b0}},
    '{'{gpioei_pkg::FUNC_WRITE, gpioei_pkg::REG_MODE,    32'h5555_5555, 16'h0000}, 1'b1,
      '{32'h0000_0000, 16'hFFFF, 16'hFFFF, 1'b0}},
    '{'{gpioei_pkg::FUNC_WRITE, gpioei_pkg::REG_MODE,    32'hAAAA_AAAA, 16'h0000}, 1'b1,
      '{32'h0000_0000, 16'hFFFF, 16'hFFFF, 1'b0}},
    '{'{gpioei_pkg::FUNC_WRITE, gpioei_pkg::REG_MODE,    32'hFFFF_FFFF, 16'h0000}, 1'b1,
      '{32'h0000_0000, 16'hFFFF, 16'h0000, 1'b0}},
    '{'{gpioei_pkg::FUNC_READ,  gpioei_pkg::REG_MODE,    32'h0000_0000, 16'h0000}, 1'b1,
      '{32'hFFFF_FFFF, 16'hFFFF, 16'h0000, 1'b0}},
    '{'{gpioei_pkg::FUNC_WRITE, gpioei_pkg::REG_MODE,    32'h0000_0009, 16'h0000}, 1'b1,
      '{32'h0000_0000, 16'hFFFF, 16'h0003, 1'b0}},
    '{'{gpioei_pkg::FUNC_WRITE, gpioei_pkg::REG_OTYPE,   32'hFFFF_FFFF, 16'h0000}, 1'b0, '0},
    '{'{gpioei_pkg::FUNC_READ,  gpioei_pkg::REG_OTYPE,   32'h0000_0000, 16'h0000}, 1'b1,
      '{32'h0000_FFFF, 16'hFFFF, 16'h0003, 1'b0}},
    '{'{gpioei_pkg::FUNC_WRITE, gpioei_pkg::REG_SPEED,   32'hFFFF_FFFF, 16'h0000}, 1'b0, '0},
    '{'{gpioei_pkg::FUNC_WRITE, gpioei_pkg::REG_PULL,    32'hAAAA_AAAA, 16'h0000}, 1'b0, '0},
    '{'{gpioei_pkg::FUNC_WRITE, gpioei_pkg::REG_AFLOW,   32'hFFFF_FFFF, 16'h0000}, 1'b0, '0},
    '{'{gpioei_pkg::FUNC_WRITE, gpioei_pkg::REG_AFHIGH,  32'h1234_5678, 16'h0000}, 1'b0, '0},
    '{'{gpioei_pkg::FUNC_READ,  gpioei_pkg::REG_AFHIGH,  32'h0000_0000, 16'h0000}, 1'b0, '0},
    '{'{gpioei_pkg::FUNC_WRITE, gpioei_pkg::REG_IDR,     32'hFFFF_FFFF, 16'h0000}, 1'b0, '0},
    '{'{gpioei_pkg::FUNC_READ,  gpioei_pkg::REG_IDR,     32'h0000_0000, 16'h0000}, 1'b1,
      '{32'h0000_0000, 16'hFFFF, 16'h0003, 1'b0}},
    '{'{gpioei_pkg::FUNC_WRITE, gpioei_pkg::REG_RISE,    32'hFFFF_0F0F, 16'h0000}, 1'b0, '0},
    '{'{gpioei_pkg::FUNC_WRITE, gpioei_pkg::REG_FALL,    32'h0000_F0F0, 16'h0000}, 1'b0, '0},
    '{'{gpioei_pkg::FUNC_WRITE, gpioei_pkg::REG_MASK,    32'h0000_00FF, 16'h0000}, 1'b0, '0},
    '{'{gpioei_pkg::FUNC_SAMPLE, gpioei_pkg::REG_MODE,   32'h0000_0000, 16'hFFFF}, 1'b0, '0},
    '{'{gpioei_pkg::FUNC_SAMPLE, gpioei_pkg::REG_MODE,   32'h0000_0000, 16'h0000}, 1'b0, '0},
    '{'{gpioei_pkg::FUNC_WRITE, gpioei_pkg::REG_PENDING, 32'h0000_00FF, 16'h0000}, 1'b0, '0},
    '{'{gpioei_pkg::FUNC_READ,  REG_UNUSED_FIRST, 32'h0000_0000, 16'h0000}, 1'b0, '0},
    '{'{FUNC_NONE,  gpioei_pkg::REG_PENDING, 32'hFFFF_FFFF, 16'hFFFF}, 1'b0, '0},
    '{'{gpioei_pkg::FUNC_WRITE, REG_UNUSED_LAST, 32'hFFFF_FFFF, 16'h0000}, 1'b0, '0},
    '{'{gpioei_pkg::FUNC_WRITE, gpioei_pkg::REG_PENDING, 32'hFFFF_FFFF, 16'h0000}, 1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  func = gpioei_pkg::FUNC_READ;
  logic [3:0]  reg_sel = gpioei_pkg::REG_MODE;
  logic [31:0] write_data = '0;
  logic [15:0] pin_levels = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] read_data;
  logic [15:0] pin_drive;
  logic [15:0] pin_out_enable;
  logic        irq;

  // Typed expectation that travels with the item on the bus
  logic                fixed_on = 1'b0;
  gpioei_pkg::result_t fixed_want = '0;

  // Predicted port state
  logic [31:0] p_mode = '0, p_speed = '0, p_pull = '0, p_af_lo = '0, p_af_hi = '0;
  logic [15:0] p_otype = '0, p_idr = '0, p_odr = '0;
  logic [15:0] p_rise = '0, p_fall = '0, p_imask = '0, p_pend = '0;

  gpioei_pkg::result_t port_results_q [$];
  int          mismatches = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          holds_asked = 0;
  int          holds_served = 0;
  int          quiet_cycles = 0;
  logic [15:0] last_levels = '0;

  gpio_port_with_edge_interrupts u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (func),
    .reg_sel        (reg_sel),
    .write_data     (write_data),
    .pin_levels     (pin_levels),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .read_data      (read_data),
    .pin_drive      (pin_drive),
    .pin_out_enable (pin_out_enable),
    .irq            (irq)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Apply one item to the predicted state and return the port's result
  function automatic gpioei_pkg::result_t port_step(logic [1:0] f, logic [3:0] sel,
                                                    logic [31:0] wd, logic [15:0] lv);
    gpioei_pkg::result_t r;
    logic [15:0]         now;
    logic [1:0]          m;
    r = '0;
    case (f)
      gpioei_pkg::FUNC_READ: begin
        case (sel)
          gpioei_pkg::REG_MODE:    r.read_data = p_mode;
          gpioei_pkg::REG_OTYPE:   r.read_data = {16'h0, p_otype};
          gpioei_pkg::REG_SPEED:   r.read_data = p_speed;
          gpioei_pkg::REG_PULL:    r.read_data = p_pull;
          gpioei_pkg::REG_IDR:     r.read_data = {16'h0, p_idr};
          gpioei_pkg::REG_ODR:     r.read_data = {16'h0, p_odr};
          gpioei_pkg::REG_AFLOW:   r.read_data = p_af_lo;
          gpioei_pkg::REG_AFHIGH:  r.read_data = p_af_hi;
          gpioei_pkg::REG_RISE:    r.read_data = {16'h0, p_rise};
          gpioei_pkg::REG_FALL:    r.read_data = {16'h0, p_fall};
          gpioei_pkg::REG_MASK:    r.read_data = {16'h0, p_imask};
          gpioei_pkg::REG_PENDING: r.read_data = {16'h0, p_pend};
          default:                 r.read_data = '0;
        endcase
      end
      gpioei_pkg::FUNC_WRITE: begin
        case (sel)
          gpioei_pkg::REG_MODE:    p_mode = wd & gpioei_pkg::FIELD2_MASK;
          gpioei_pkg::REG_OTYPE:   p_otype = wd[15:0] & gpioei_pkg::PIN_MASK;
          gpioei_pkg::REG_SPEED:   p_speed = wd & gpioei_pkg::FIELD2_MASK;
          gpioei_pkg::REG_PULL:    p_pull = wd & gpioei_pkg::FIELD2_MASK;
          gpioei_pkg::REG_ODR:     p_odr = wd[15:0] & gpioei_pkg::PIN_MASK;
          gpioei_pkg::REG_AFLOW:   p_af_lo = wd & gpioei_pkg::AF_LO_MASK;
          gpioei_pkg::REG_AFHIGH:  p_af_hi = wd & gpioei_pkg::AF_HI_MASK;
          gpioei_pkg::REG_RISE:    p_rise = wd[15:0] & gpioei_pkg::PIN_MASK;
          gpioei_pkg::REG_FALL:    p_fall = wd[15:0] & gpioei_pkg::PIN_MASK;
          gpioei_pkg::REG_MASK:    p_imask = wd[15:0] & gpioei_pkg::PIN_MASK;
          gpioei_pkg::REG_PENDING: p_pend = p_pend & ~(wd[15:0] & gpioei_pkg::PIN_MASK);
          default:                 ;
        endcase
      end
      gpioei_pkg::FUNC_SAMPLE: begin
        // Edges are judged against the previous sample
        now = lv & gpioei_pkg::PIN_MASK;
        p_pend = p_pend | (((now & ~p_idr & p_rise) | (~now & p_idr & p_fall))
                           & gpioei_pkg::PIN_MASK);
        p_idr = now;
      end
      default: ;
    endcase
    r.pin_drive = p_odr;
    for (int p = 0; p < 16; p++) begin
      m = p_mode[2*p +: 2];
      r.pin_out_enable[p] = (m == gpioei_pkg::MODE_OUTPUT) || (m == gpioei_pkg::MODE_ALTERNATE);
    end
    r.pin_out_enable = r.pin_out_enable & gpioei_pkg::PIN_MASK;
    r.irq = |(p_pend & p_imask);
    return r;
  endfunction

  // Mostly samples and register traffic; some pin changes touch a single pin
  function automatic gpioei_pkg::item_t random_access();
    gpioei_pkg::item_t it;
    int unsigned       pick;
    pick = $urandom_range(0, 99);
    it.write_data = $urandom();
    if ($urandom_range(0, 9) == 0) begin
      it.write_data = ($urandom_range(0, 1) == 1) ? '1 : '0;
    end
    if ($urandom_range(0, 1) == 1) begin
      it.pin_levels = 16'($urandom());
    end else begin
      it.pin_levels = last_levels ^ (16'h1 << $urandom_range(0, 15));
    end
    if ($urandom_range(0, 19) == 0) begin
      it.reg_sel = 4'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST));
    end else begin
      it.reg_sel = 4'($urandom_range(gpioei_pkg::REG_MODE, gpioei_pkg::REG_PENDING));
    end
    if (pick < 35) begin
      it.func = gpioei_pkg::FUNC_SAMPLE;
    end else if (pick < 65) begin
      it.func = gpioei_pkg::FUNC_WRITE;
    end else if (pick < 96) begin
      it.func = gpioei_pkg::FUNC_READ;
    end else begin
      it.func = FUNC_NONE;
    end
    if (it.func == gpioei_pkg::FUNC_SAMPLE) begin
      last_levels = it.pin_levels;
    end
    return it;
  endfunction

  // Offer one item, idling first at the current rate, and hold it until taken
  task automatic send_item(input gpioei_pkg::item_t it, input logic typed,
                           input gpioei_pkg::result_t want);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    func       <= it.func;
    reg_sel    <= it.reg_sel;
    write_data <= it.write_data;
    pin_levels <= it.pin_levels;
    fixed_on   <= typed;
    fixed_want <= want;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    items_sent++;
  endtask

  // Drop valid and wait until every predicted result has arrived
  task automatic wait_results();
    in_valid <= 1'b0;
    while (results_seen != items_sent) begin
      @(posedge clk);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Receiver: random stalls plus long hold-offs on request
  initial begin
    forever begin
      @(posedge clk);
      if (holds_served != holds_asked) begin
        holds_served++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Predict on accepted items, compare on accepted results
  always @(posedge clk) begin : scoreboard
    gpioei_pkg::result_t want;
    gpioei_pkg::result_t got;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        want = port_step(func, reg_sel, write_data, pin_levels);
        if (fixed_on) begin
          want = fixed_want;
        end
        port_results_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got.read_data      = read_data;
        got.pin_drive      = pin_drive;
        got.pin_out_enable = pin_out_enable;
        got.irq            = irq;
        if (port_results_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          mismatches++;
        end else begin
          want = port_results_q.pop_front();
          check_field("read_data", want.read_data, got.read_data);
          check_field("pin_drive", {16'h0, want.pin_drive}, {16'h0, got.pin_drive});
          check_field("pin_out_enable", {16'h0, want.pin_out_enable},
                      {16'h0, got.pin_out_enable});
          check_field("irq", {31'h0, want.irq}, {31'h0, got.irq});
          results_seen++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, no handshake in %0d cycles", $time, IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    for (int i = 0; i < NUM_ROWS; i++) begin
      send_item(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    end
    wait_results();

    // Hold the receiver off while items keep coming, so the input backs up
    holds_asked++;
    repeat (FILL_ITEMS) send_item(random_access(), 1'b0, '0);
    wait_results();

    // Random phases: none, sender idle, receiver stall, both, none
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        1:       begin idle_pct = 76; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 76; end
        3:       begin idle_pct = 33; stall_pct = 33; end
        default: begin idle_pct = 0;  stall_pct = 0;  end
      endcase
      repeat (PHASE_ITEMS) send_item(random_access(), 1'b0, '0);
      wait_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && port_results_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/gpioei_pkg.sv
rtl/gpioei_regs.sv
rtl/gpio_port_with_edge_interrupts.sv
verif/gpio_port_with_edge_interrupts_test.sv
